[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands; expect i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Overlapping implication checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/utra_pkg.sv]
// ----------------------------------------------------------------------------
// utra_pkg
// Shared constants and types for the transmit ring with message admission.
// ----------------------------------------------------------------------------
package utra_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CTR_W      = 32;
    localparam int CMD_W      = 2;
    localparam int FREE_W     = 8;
    localparam int FREE_MAX   = 255;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_DONE  = 2'd2
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } t_ram_req;

endpackage

[rtl/utra_ram.sv]
// ----------------------------------------------------------------------------
// utra_ram
// Ring byte store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module utra_ram import utra_pkg::*; (
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/uart_transmit_ring_with_admission.sv]
// Each accepted item's result is registered; an item that hands a byte to the
// transmitter first does a registered read of the ring memory (S_FETCH).
// One item per cycle while results are taken; none is taken during S_FETCH.
// The result register frees in the cycle its item is taken downstream.
// Reset (synchronous, active low) clears state, pointers, counters and the
// active and result-valid flags; ring memory and other outputs are not cleared.
// ----------------------------------------------------------------------------
// uart_transmit_ring_with_admission
// Transmit ring buffer admitting whole messages, with sent/refused counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_transmit_ring_with_admission import utra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [LEN_W-1:0]  i_message_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_accepted,
    output logic              o_line_valid,
    output logic [BYTE_W-1:0] o_line_byte,
    output logic              o_sending,
    output logic [FREE_W-1:0] o_free_space,
    output logic [CTR_W-1:0]  o_sent_total,
    output logic [CTR_W-1:0]  o_refused_total
);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic              r_active, n_active;
    logic [LEN_W-1:0]  r_remaining, n_remaining;
    logic [CTR_W-1:0]  r_sent, n_sent;
    logic [CTR_W-1:0]  r_refused, n_refused;
    logic              r_out_valid, n_out_valid;
    logic              r_accepted, n_accepted;
    logic              r_line_valid, n_line_valid;
    logic [BYTE_W-1:0] r_line_byte, n_line_byte;
    logic [FREE_W-1:0] r_free, n_free;
    logic              r_fwd_hit, n_fwd_hit;
    logic [BYTE_W-1:0] r_fwd_byte, n_fwd_byte;

    t_ram_req          ram_req;
    logic [BYTE_W-1:0] ram_rd_data;
    logic              take;
    logic              send;
    logic [CNT_W-1:0]  occ_now, space_now, occ_next, space_next;
    logic [LEN_W:0]    free_wide;

    utra_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] occupancy(input logic [PTR_W-1:0] wp,
                                                   input logic [PTR_W-1:0] rp);
        logic [CNT_W-1:0] diff;
        diff = CNT_W'(wp) - CNT_W'(rp);
        return (wp < rp) ? diff + CNT_W'(RING_DEPTH) : diff;
    endfunction

    assign occ_now   = occupancy(r_wp, r_rp);
    assign space_now = CNT_W'(RING_DEPTH - 1) - occ_now;

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_active     = r_active;
        n_remaining  = r_remaining;
        n_sent       = r_sent;
        n_refused    = r_refused;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_accepted   = r_accepted;
        n_line_valid = r_line_valid;
        n_line_byte  = r_line_byte;
        n_free       = r_free;
        n_fwd_hit    = r_fwd_hit;
        n_fwd_byte   = r_fwd_byte;
        send         = 1'b0;
        ram_req      = '0;
        ram_req.wr_addr = r_wp;
        ram_req.wr_data = i_data_byte;
        ram_req.rd_addr = r_rp;

        o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
        take       = i_in_valid && o_in_ready;

        if (take) begin
            n_accepted = 1'b0;
            case (t_cmd'(i_command))
                CMD_BEGIN: begin
                    if (i_message_length != '0 && r_remaining == '0) begin
                        if ({1'b0, i_message_length} > (LEN_W+1)'(space_now)) begin
                            n_refused = r_refused + 1'b1;
                        end else begin
                            n_remaining = i_message_length;
                            n_accepted  = 1'b1;
                        end
                    end
                end
                CMD_DATA: begin
                    if (r_remaining != '0) begin
                        ram_req.wr_en = 1'b1;
                        n_wp          = ptr_inc(r_wp);
                        n_remaining   = r_remaining - 1'b1;
                        n_accepted    = 1'b1;
                        if (r_remaining == LEN_W'(1) && !r_active) begin
                            n_active  = 1'b1;
                            send      = 1'b1;
                            n_fwd_hit = (r_rp == r_wp);
                        end
                    end
                end
                CMD_DONE: begin
                    if (r_active) begin
                        if (r_rp == r_wp) begin
                            n_active = 1'b0;
                        end else begin
                            send      = 1'b1;
                            n_fwd_hit = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (send) begin
                ram_req.rd_en = 1'b1;
                n_rp          = ptr_inc(r_rp);
                n_sent        = r_sent + 1'b1;
                n_state       = S_FETCH;
            end else begin
                n_out_valid   = 1'b1;
            end
            n_line_valid = send;
            n_line_byte  = '0;
            n_fwd_byte   = i_data_byte;
        end

        if (r_state == S_FETCH) begin
            n_line_byte = r_fwd_hit ? r_fwd_byte : ram_rd_data;
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
        end

        occ_next   = occupancy(n_wp, n_rp);
        space_next = CNT_W'(RING_DEPTH - 1) - occ_next;
        free_wide  = ((LEN_W+1)'(space_next) > {1'b0, n_remaining})
                   ? (LEN_W+1)'(space_next) - {1'b0, n_remaining} : '0;
        if (take) begin
            n_free = (free_wide > (LEN_W+1)'(FREE_MAX)) ? FREE_W'(FREE_MAX)
                                                       : free_wide[FREE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_active    <= 1'b0;
            r_remaining <= '0;
            r_sent      <= '0;
            r_refused   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_active    <= n_active;
            r_remaining <= n_remaining;
            r_sent      <= n_sent;
            r_refused   <= n_refused;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted   <= n_accepted;
        r_line_valid <= n_line_valid;
        r_line_byte  <= n_line_byte;
        r_free       <= n_free;
        r_fwd_hit    <= n_fwd_hit;
        r_fwd_byte   <= n_fwd_byte;
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_line_valid    = r_line_valid;
    assign o_line_byte     = r_line_byte;
    assign o_sending       = r_active;
    assign o_free_space    = r_free;
    assign o_sent_total    = r_sent;
    assign o_refused_total = r_refused;

    `ASSERT_IMPL(a_fetch_out_empty, r_state == S_FETCH, !r_out_valid, "fetch with result pending")
    `ASSERT_NEXT(a_fetch_completes, r_state == S_FETCH, r_out_valid && r_line_valid && r_state == S_IDLE, "fetch did not complete")
    `ASSERT_IMPL(a_send_active, r_out_valid && r_line_valid, r_active, "byte sent while idle")
    `ASSERT_CLK(a_ring_not_full, occ_now != CNT_W'(RING_DEPTH), "ring occupancy overflow")

endmodule
